// File: rtl/phac_pkg.sv
// Package for the private host address check unit.
// Holds the parser state and result types shared by the parse logic and the top level.
// No dependencies.
package phac_pkg;

  // Dotted quad parse state.
  typedef struct packed {
    logic [7:0]  octet_value;
    logic [1:0]  digit_count;
    logic [2:0]  octet_index;
    logic [31:0] address_word;
    logic        quad_broken;
  } quad_st_t;

  // Name prefix tracking state.
  typedef struct packed {
    logic [2:0] name_length;
    logic [7:0] previous_byte;
    logic [4:0] prefix_flags;
  } name_st_t;

  typedef struct packed {
    quad_st_t quad;
    name_st_t name;
  } parse_st_t;

  typedef struct packed {
    logic        is_private;
    logic        is_ipv4;
    logic [31:0] ipv4_address;
  } result_t;

endpackage

// File: rtl/phac_parse.sv
// Per-byte parse logic: lowers the byte, updates the quad parser and the name
// prefix flags, and forms the result on the final byte. Uses phac_pkg.
module phac_parse import phac_pkg::*; (
  input  parse_st_t  st,
  input  logic [7:0] host_byte,
  input  logic       last_byte,
  output parse_st_t  st_next,
  output result_t    res
);

  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_8      = 8'h38;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5a;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;

  localparam int PF_LOOP3   = 0;
  localparam int PF_LOOP5   = 1;
  localparam int PF_BRACKET = 2;
  localparam int PF_UNIQUE  = 3;
  localparam int PF_LINK    = 4;

  function automatic quad_st_t quad_feed(input quad_st_t q, input logic [7:0] c);
    quad_st_t    r;
    logic [11:0] v;
    r = q;
    v = ({4'd0, q.octet_value} << 3) + ({4'd0, q.octet_value} << 1) + {8'd0, c[3:0]};
    if (!q.quad_broken) begin
      if (c >= CH_0 && c <= CH_9) begin
        if (q.digit_count == 2'd3 || v > 12'd255) begin
          r.quad_broken = 1'b1;
        end else begin
          r.octet_value = v[7:0];
          r.digit_count = q.digit_count + 2'd1;
        end
      end else if (c != CH_DOT || q.digit_count == 2'd0 || q.octet_index > 3'd3) begin
        r.quad_broken = 1'b1;
      end else begin
        r.address_word = {q.address_word[23:0], q.octet_value};
        r.octet_index  = q.octet_index + 3'd1;
        r.octet_value  = 8'd0;
        r.digit_count  = 2'd0;
      end
    end
    return r;
  endfunction

  function automatic name_st_t name_feed(input name_st_t n, input logic [7:0] c);
    name_st_t   r;
    logic [2:0] p;
    logic       loop3_ok;
    logic       loop5_ok;
    r = n;
    p = n.name_length;
    if (p == 3'd0) begin
      r.prefix_flags = 5'd0;
      if (c == CH_COLON) r.prefix_flags[PF_LOOP3] = 1'b1;
      if (c == CH_LBRACK) begin
        r.prefix_flags[PF_LOOP5]   = 1'b1;
        r.prefix_flags[PF_BRACKET] = 1'b1;
      end
    end else begin
      case (p)
        3'd1:    loop3_ok = (c == CH_COLON);
        3'd2:    loop3_ok = (c == CH_1);
        default: loop3_ok = 1'b0;
      endcase
      case (p)
        3'd1:    loop5_ok = (c == CH_COLON);
        3'd2:    loop5_ok = (c == CH_COLON);
        3'd3:    loop5_ok = (c == CH_1);
        3'd4:    loop5_ok = (c == CH_RBRACK);
        default: loop5_ok = 1'b0;
      endcase
      if (!loop3_ok) r.prefix_flags[PF_LOOP3] = 1'b0;
      if (!loop5_ok) r.prefix_flags[PF_LOOP5] = 1'b0;
      // The link-local pattern starts one byte in, after the bracket.
      case (p)
        3'd1: if (c == CH_F) r.prefix_flags[PF_LINK] = 1'b1;
        3'd2: if (c != CH_E) r.prefix_flags[PF_LINK] = 1'b0;
        3'd3: if (c != CH_8) r.prefix_flags[PF_LINK] = 1'b0;
        3'd4: if (c != CH_0) r.prefix_flags[PF_LINK] = 1'b0;
        3'd5: if (c != CH_COLON) r.prefix_flags[PF_LINK] = 1'b0;
        default: ;
      endcase
      if (p == 3'd2 && n.previous_byte == CH_F && (c == CH_C || c == CH_D)) begin
        r.prefix_flags[PF_UNIQUE] = 1'b1;
      end
    end
    if (n.name_length != 3'd7) r.name_length = n.name_length + 3'd1;
    r.previous_byte = c;
    return r;
  endfunction

  logic [7:0] c;
  logic       drop;
  quad_st_t   q1;
  quad_st_t   qf;
  name_st_t   n1;
  logic       v4;
  logic [31:0] a;
  logic [7:0] o0;
  logic [7:0] o1;
  logic       priv;

  always_comb begin
    c = host_byte;
    if (host_byte >= CH_UA && host_byte <= CH_UZ) c = host_byte + 8'h20;
    // A final dot is dropped unless it is the only byte or follows another dot.
    drop = last_byte && c == CH_DOT && st.name.name_length != 3'd0 &&
           st.name.previous_byte != CH_DOT;
    q1 = drop ? st.quad : quad_feed(st.quad, c);
    n1 = drop ? st.name : name_feed(st.name, c);
    qf = quad_feed(q1, CH_DOT);
    v4 = !qf.quad_broken && qf.octet_index == 3'd4;
    a  = v4 ? qf.address_word : 32'd0;
    o0 = a[31:24];
    o1 = a[23:16];
    if ((n1.prefix_flags[PF_LOOP3] && n1.name_length == 3'd3) ||
        (n1.prefix_flags[PF_LOOP5] && n1.name_length == 3'd5)) begin
      priv = 1'b1;
    end else if (n1.name_length > 3'd2 && n1.prefix_flags[PF_BRACKET]) begin
      priv = n1.prefix_flags[PF_UNIQUE] ||
             (n1.prefix_flags[PF_LINK] && n1.name_length >= 3'd6);
    end else if (v4) begin
      priv = (o0 == 8'd127) || (o0 == 8'd10) ||
             (o0 == 8'd192 && o1 == 8'd168) ||
             (o0 == 8'd172 && o1 >= 8'd16 && o1 <= 8'd31) ||
             (o0 == 8'd169 && o1 == 8'd254) ||
             (a == 32'd0);
    end else begin
      priv = 1'b0;
    end
    res.is_private   = priv;
    res.is_ipv4      = v4;
    res.ipv4_address = a;
    // The parser returns to its reset state after each name.
    if (last_byte) begin
      st_next = '0;
    end else begin
      st_next.quad = q1;
      st_next.name = n1;
    end
  end

endmodule

// File: rtl/private_host_address_check_unit.sv
// Top level of the private host address check unit: input register, parser
// state, result register. Uses phac_pkg and phac_parse.
//
//   Channel | Ports                                      | Direction
//   in      | in_valid, in_stall, in_host_byte, in_last_byte | byte stream in
//   out     | out_valid, out_stall, out_is_private,       | one result per name
//           | out_is_ipv4, out_ipv4_address               |
//
// One byte is accepted every cycle while in_stall is low. The result register loads
// when the final byte of a name advances out of the input register, which a held
// result can delay.
// Reset clears the valid flags and the parser state.
// A held result stalls the input only when the registered byte is a final
// byte; other bytes keep flowing while the result waits.
module private_host_address_check_unit import phac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_host_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_private,
  output logic        out_is_ipv4,
  output logic [31:0] out_ipv4_address
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  parse_st_t  st_r;
  parse_st_t  st_nxt;
  result_t    res;
  logic       out_valid_r;
  result_t    out_res_r;
  logic       out_free;
  logic       adv;

  phac_parse u_parse (
    .st        (st_r),
    .host_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .st_next   (st_nxt),
    .res       (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_host_byte;
      s1_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_private   = out_res_r.is_private;
  assign out_is_ipv4      = out_res_r.is_ipv4;
  assign out_ipv4_address = out_res_r.ipv4_address;

endmodule
